@@ src/dmm_pkg.sv @@
package dmm_pkg;

  // element and result value width (signed Q16.16)
  localparam int VALUE_W = 32;
  // width of a dimension register
  localparam int DIM_W = 4;
  // width of row, column and inner index fields
  localparam int IDX_W = 3;
  // width of the configuration register index
  localparam int CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int MAX_DIM_DEFAULT = 8;
  localparam int FRAC_BITS_DEFAULT = 16;

  // dimension register value after reset
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN
  } dmm_state_t;

  // tag travelling alongside each multiply-accumulate
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } dmm_tag_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v,
                                                logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    begin
      r = v;
      if (v == '0) r = DIM_W'(1);
      if (v > max_dim) r = max_dim;
      return r;
    end
  endfunction

endpackage

@@ src/dmm_ram.sv @@
module dmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/dmm_mac.sv @@
module dmm_mac #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT,
  parameter int FRAC_BITS = dmm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [dmm_pkg::VALUE_W-1:0]  a_data,
  input  logic signed [dmm_pkg::VALUE_W-1:0]  b_data,
  input  dmm_pkg::dmm_tag_t                   tag_in,
  output logic                                strobe,
  output logic signed [dmm_pkg::VALUE_W-1:0]  product_value,
  output logic [dmm_pkg::IDX_W-1:0]           out_row,
  output logic [dmm_pkg::IDX_W-1:0]           out_col,
  output logic                                last_element
);

  localparam int PROD_W = 2 * dmm_pkg::VALUE_W;
  localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int VW = dmm_pkg::VALUE_W;

  dmm_pkg::dmm_tag_t       tag_mul;
  dmm_pkg::dmm_tag_t       tag_acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;
  logic [VW-1:0]            sat_value;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mul.valid <= 1'b0;
    end else begin
      tag_mul.valid <= tag_in.valid;
    end
    tag_mul.first <= tag_in.first;
    tag_mul.last_k <= tag_in.last_k;
    tag_mul.row <= tag_in.row;
    tag_mul.col <= tag_in.col;
    tag_mul.last <= tag_in.last;
    prod <= a_data * b_data;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // accumulate stage, full precision
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_acc.valid <= 1'b0;
    end else begin
      tag_acc.valid <= tag_mul.valid;
    end
    tag_acc.first <= tag_mul.first;
    tag_acc.last_k <= tag_mul.last_k;
    tag_acc.row <= tag_mul.row;
    tag_acc.col <= tag_mul.col;
    tag_acc.last <= tag_mul.last;
    if (tag_mul.valid) begin
      acc <= tag_mul.first ? prod_ext : acc + prod_ext;
    end
  end

  // floor shift back to Q16.16 and saturate
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    fits = (&shifted[ACC_W-1:VW-1]) || !(|shifted[ACC_W-1:VW-1]);
    if (fits) begin
      sat_value = shifted[VW-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag_acc.valid && tag_acc.last_k;
    end
    product_value <= sat_value;
    out_row <= tag_acc.row;
    out_col <= tag_acc.col;
    last_element <= tag_acc.last;
  end

endmodule

@@ src/dense_matrix_multiply.sv @@
// Dense matrix multiply C = A x B on column-major signed Q16.16 matrices.
// Set a_rows, inner_dim and b_cols (0 reads as 1, above MAX_DIM as MAX_DIM)
// while busy is low; a write to any of them restarts loading with A. Feed A
// (a_rows x inner_dim) then B (inner_dim x b_cols) column-major, one
// element per cycle on start while busy is low. The element that completes
// B raises busy; the block then issues a_rows * b_cols * inner_dim products
// on a single shared multiply-accumulate fed from the two element memories;
// results pass the memory read, multiply, accumulate and result registers
// after their last product is issued, one per strobe, column by column, row
// 0 upward. Results cannot be held off: each is on the ports for one cycle
// only. busy falls the cycle after the strobe that carries last_element.
module dense_matrix_multiply #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT,
  parameter int FRAC_BITS = dmm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dmm_pkg::VALUE_W-1:0]  element_value,
  input  logic                                cfg_write,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]           cfg_data,
  output logic                                strobe,
  output logic signed [dmm_pkg::VALUE_W-1:0]  product_value,
  output logic [dmm_pkg::IDX_W-1:0]           out_row,
  output logic [dmm_pkg::IDX_W-1:0]           out_col,
  output logic                                last_element
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DW = dmm_pkg::DIM_W;
  localparam int IW = dmm_pkg::IDX_W;
  localparam int LIN_W = 2 * DW;
  localparam int VW_T = dmm_pkg::VALUE_W;

  dmm_pkg::dmm_state_t state;
  dmm_pkg::dmm_state_t state_next;

  logic [DW-1:0]     a_rows;
  logic [DW-1:0]     inner_dim;
  logic [DW-1:0]     b_cols;
  logic [DW-1:0]     r_eff;
  logic [DW-1:0]     n_eff;
  logic [DW-1:0]     c_eff;
  logic [CNT_W-1:0]  load_count;
  logic              loading_b;
  logic [LIN_W-1:0]  load_inc;
  logic [LIN_W-1:0]  a_total;
  logic [LIN_W-1:0]  b_total;
  logic              accept;
  logic              a_we;
  logic              b_we;
  logic              load_done;
  logic              cfg_hit;

  logic [IW-1:0]     ci;
  logic [IW-1:0]     cj;
  logic [IW-1:0]     ck;
  logic              k_end;
  logic              j_end;
  logic              i_end;
  logic              issue;
  logic              issue_last;
  logic [LIN_W-1:0]  a_lin;
  logic [LIN_W-1:0]  b_lin;
  logic [VW_T-1:0]   a_rdata;
  logic [VW_T-1:0]   b_rdata;
  dmm_pkg::dmm_tag_t tag_rd;

  // effective dimensions
  assign r_eff = dmm_pkg::eff_dim(a_rows, DW'(MAX_DIM));
  assign n_eff = dmm_pkg::eff_dim(inner_dim, DW'(MAX_DIM));
  assign c_eff = dmm_pkg::eff_dim(b_cols, DW'(MAX_DIM));
  assign a_total = LIN_W'(r_eff) * LIN_W'(n_eff);
  assign b_total = LIN_W'(n_eff) * LIN_W'(c_eff);

  // load handshake
  assign accept = start && !busy;
  assign a_we = accept && !loading_b;
  assign b_we = accept && loading_b;
  assign load_inc = LIN_W'(load_count) + LIN_W'(1);
  assign load_done = b_we && (load_inc >= b_total);
  assign cfg_hit = cfg_write && (cfg_index == dmm_pkg::REG_A_ROWS ||
                   cfg_index == dmm_pkg::REG_INNER_DIM ||
                   cfg_index == dmm_pkg::REG_B_COLS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= dmm_pkg::DIM_RESET;
      inner_dim <= dmm_pkg::DIM_RESET;
      b_cols <= dmm_pkg::DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dmm_pkg::REG_A_ROWS: a_rows <= cfg_data;
        dmm_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        dmm_pkg::REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // load counter and matrix select
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_count <= '0;
      loading_b <= 1'b0;
    end else if (a_we) begin
      if (load_inc >= a_total) begin
        load_count <= '0;
        loading_b <= 1'b1;
      end else begin
        load_count <= CNT_W'(load_inc);
      end
    end else if (b_we) begin
      if (load_done) begin
        load_count <= '0;
        loading_b <= 1'b0;
      end else begin
        load_count <= CNT_W'(load_inc);
      end
    end
  end

  // issue counters: k innermost, then row, then column
  assign k_end = ({1'b0, ck} == n_eff - DW'(1));
  assign j_end = ({1'b0, cj} == r_eff - DW'(1));
  assign i_end = ({1'b0, ci} == c_eff - DW'(1));
  assign issue_last = k_end && j_end && i_end;

  always_ff @(posedge clk) begin
    if (rst || state != dmm_pkg::ST_ISSUE) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (k_end) begin
      ck <= '0;
      if (j_end) begin
        cj <= '0;
        ci <= ci + IW'(1);
      end else begin
        cj <= cj + IW'(1);
      end
    end else begin
      ck <= ck + IW'(1);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmm_pkg::ST_LOAD: if (load_done) state_next = dmm_pkg::ST_ISSUE;
      dmm_pkg::ST_ISSUE: if (issue_last) state_next = dmm_pkg::ST_DRAIN;
      dmm_pkg::ST_DRAIN: if (strobe && last_element) state_next = dmm_pkg::ST_LOAD;
      default: state_next = dmm_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b1;
    issue = 1'b0;
    unique case (state)
      dmm_pkg::ST_LOAD: busy = 1'b0;
      dmm_pkg::ST_ISSUE: issue = 1'b1;
      dmm_pkg::ST_DRAIN: ;
      default: busy = 1'b0;
    endcase
  end

  // read addresses: A at k*rows+j, B at i*inner+k
  assign a_lin = LIN_W'(ck) * LIN_W'(r_eff) + LIN_W'(cj);
  assign b_lin = LIN_W'(ci) * LIN_W'(n_eff) + LIN_W'(ck);

  dmm_ram #(
    .WIDTH(VW_T),
    .DEPTH(DEPTH)
  ) u_a_ram (
    .clk(clk),
    .we(a_we),
    .waddr(load_count[ADDR_W-1:0]),
    .wdata(element_value),
    .raddr(a_lin[ADDR_W-1:0]),
    .rdata(a_rdata)
  );

  dmm_ram #(
    .WIDTH(VW_T),
    .DEPTH(DEPTH)
  ) u_b_ram (
    .clk(clk),
    .we(b_we),
    .waddr(load_count[ADDR_W-1:0]),
    .wdata(element_value),
    .raddr(b_lin[ADDR_W-1:0]),
    .rdata(b_rdata)
  );

  // tag aligned with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd.valid <= 1'b0;
    end else begin
      tag_rd.valid <= issue;
    end
    tag_rd.first <= (ck == '0);
    tag_rd.last_k <= k_end;
    tag_rd.row <= cj;
    tag_rd.col <= ci;
    tag_rd.last <= j_end && i_end;
  end

  dmm_mac #(
    .MAX_DIM(MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk(clk),
    .rst(rst),
    .a_data($signed(a_rdata)),
    .b_data($signed(b_rdata)),
    .tag_in(tag_rd),
    .strobe(strobe),
    .product_value(product_value),
    .out_row(out_row),
    .out_col(out_col),
    .last_element(last_element)
  );

  // results only appear while a product is in progress
  assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result strobe outside a product run");

  // the final result ends the run
  assert property (@(posedge clk) disable iff (rst)
                   strobe && last_element |=> !busy)
    else $error("busy still high after the final result");

  // memories are written only while loading, and never both at once
  assert property (@(posedge clk) disable iff (rst)
                   (a_we || b_we) |-> (!issue && $onehot0({a_we, b_we})))
    else $error("element memory written outside loading");

endmodule

@@ dv/dmm_checker.sv @@
`timescale 1ns / 100ps

module dmm_checker #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT,
  parameter int FRAC_BITS = dmm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [dmm_pkg::VALUE_W-1:0]  element_value,
  input  logic                                cfg_write,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                strobe,
  input  logic signed [dmm_pkg::VALUE_W-1:0]  product_value,
  input  logic [dmm_pkg::IDX_W-1:0]           out_row,
  input  logic [dmm_pkg::IDX_W-1:0]           out_col,
  input  logic                                last_element,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_seen
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ACC_W = 72;
  localparam int VW = dmm_pkg::VALUE_W;
  localparam int IW = dmm_pkg::IDX_W;
  localparam int DW = dmm_pkg::DIM_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -(72'sd2147483648);
  localparam int REPORT_LIMIT = 10;

  // one element of the product matrix
  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [IW-1:0]        row;
    logic [IW-1:0]        col;
    logic                 last;
  } product_elem_t;

  product_elem_t pending_products[$];

  // shadow of the dimension registers and the element memories
  logic [DW-1:0]        rows_reg, inner_reg, cols_reg;
  logic signed [VW-1:0] a_mem[STORE_DEPTH];
  logic signed [VW-1:0] b_mem[STORE_DEPTH];
  int                   load_idx;
  bit                   load_b;
  int                   fails;
  int                   seen;
  int                   reported;

  // zero reads as one, above the maximum as the maximum
  function automatic int dim_in_use(logic [DW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // floor shift back to q16.16 and clamp to the 32 bit range
  function automatic logic signed [VW-1:0] round_and_clamp(
      logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = acc >>> FRAC_BITS;
    if (q > SAT_HI) return SAT_HI[VW-1:0];
    if (q < SAT_LO) return SAT_LO[VW-1:0];
    return q[VW-1:0];
  endfunction

  // full product matrix, column by column, row 0 upward
  task automatic multiply_stores();
    int r, n, c;
    logic signed [63:0] prod;
    logic signed [ACC_W-1:0] acc;
    product_elem_t e;
    r = dim_in_use(rows_reg);
    n = dim_in_use(inner_reg);
    c = dim_in_use(cols_reg);
    for (int col = 0; col < c; col++) begin
      for (int row = 0; row < r; row++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          prod = a_mem[k * r + row] * b_mem[col * n + k];
          acc = acc + prod;
        end
        e.value = round_and_clamp(acc);
        e.row = IW'(row);
        e.col = IW'(col);
        e.last = (col == c - 1) && (row == r - 1);
        pending_products.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    product_elem_t got;
    product_elem_t want;
    if (rst) begin
      rows_reg = dmm_pkg::DIM_RESET;
      inner_reg = dmm_pkg::DIM_RESET;
      cols_reg = dmm_pkg::DIM_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
      load_idx = 0;
      load_b = 1'b0;
      pending_products.delete();
    end else begin
      // compare each result transaction with the oldest prediction
      if (strobe) begin
        got = '{product_value, out_row, out_col, last_element};
        seen++;
        if (pending_products.size() == 0) begin
          fails++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected result: value=%0d row=%0d col=%0d last=%0b",
                     got.value, got.row, got.col, got.last);
          end
        end else begin
          want = pending_products.pop_front();
          if (got !== want) begin
            fails++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("mismatch: expected value=%0d row=%0d col=%0d last=%0b,",
                       want.value, want.row, want.col, want.last);
              $display("          got value=%0d row=%0d col=%0d last=%0b",
                       got.value, got.row, got.col, got.last);
            end
          end
        end
      end

      // register writes restart loading, unused index ignored
      if (cfg_write) begin
        case (cfg_index)
          dmm_pkg::REG_A_ROWS: begin
            rows_reg = cfg_data;
            load_idx = 0;
            load_b = 1'b0;
          end
          dmm_pkg::REG_INNER_DIM: begin
            inner_reg = cfg_data;
            load_idx = 0;
            load_b = 1'b0;
          end
          dmm_pkg::REG_B_COLS: begin
            cols_reg = cfg_data;
            load_idx = 0;
            load_b = 1'b0;
          end
          default: ;
        endcase
      end

      // element transaction: fill a then b, predict on the last of b
      if (start && !busy) begin
        if (!load_b) begin
          a_mem[load_idx] = element_value;
          load_idx++;
          if (load_idx >= dim_in_use(rows_reg) * dim_in_use(inner_reg)) begin
            load_idx = 0;
            load_b = 1'b1;
          end
        end else begin
          b_mem[load_idx] = element_value;
          load_idx++;
          if (load_idx >= dim_in_use(inner_reg) * dim_in_use(cols_reg)) begin
            load_idx = 0;
            load_b = 1'b0;
            multiply_stores();
          end
        end
      end
    end
    fail_count <= fails;
    pending <= pending_products.size();
    results_seen <= seen;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int VW = dmm_pkg::VALUE_W;
  localparam int DW = dmm_pkg::DIM_W;
  localparam int CW = dmm_pkg::CFG_IDX_W;
  localparam int IW = dmm_pkg::IDX_W;
  localparam logic [CW-1:0] REG_UNUSED = '1;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 20;

  // corner values: a is 1 x 8, b is 8 x 1
  localparam logic signed [VW-1:0] CORNER_VALUES[16] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0001,
    32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 32'sh0000_0000,
    32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF,
    32'sh0002_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0003
  };

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [VW-1:0] element_value;
  logic                 cfg_write;
  logic [CW-1:0]        cfg_index;
  logic [DW-1:0]        cfg_data;
  logic                 strobe;
  logic signed [VW-1:0] product_value;
  logic [IW-1:0]        out_row;
  logic [IW-1:0]        out_col;
  logic                 last_element;

  int fail_count;
  int pending;
  int results_seen;
  int elements_sent;
  int settings_used;
  logic [DW-1:0] dims[3];

  dense_matrix_multiply dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .product_value(product_value),
    .out_row(out_row), .out_col(out_col), .last_element(last_element)
  );

  dmm_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .product_value(product_value),
    .out_row(out_row), .out_col(out_col), .last_element(last_element),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int dim_used(logic [DW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > dmm_pkg::MAX_DIM_DEFAULT) return dmm_pkg::MAX_DIM_DEFAULT;
    return int'(v);
  endfunction

  // elements needed for one full a and b load
  function automatic int load_length();
    return dim_used(dims[0]) * dim_used(dims[1]) +
           dim_used(dims[1]) * dim_used(dims[2]);
  endfunction

  // mostly small sizes, now and then zero, oversize or large
  function automatic logic [DW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DW'($urandom_range(9, 15));
      2: return DW'($urandom_range(4, 8));
      default: return DW'($urandom_range(1, 3));
    endcase
  endfunction

  // mix of raw words, moderate fractions and range ends
  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 20) - (1 << 19);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'shFFFF_FFFF;
          default: return 32'sh0000_0001;
        endcase
      end
      default: return $urandom_range(0, 1 << 17) - (1 << 16);
    endcase
  endfunction

  // hold the element until a transaction completes
  task automatic send_element(input logic signed [VW-1:0] v);
    start <= 1'b1;
    element_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    elements_sent++;
  endtask

  // each cycle the sender idles with the given chance
  task automatic send_random(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      send_element(pick_value());
    end
  endtask

  // caller lowers cfg_write after the last write of a group
  task automatic write_reg(input logic [CW-1:0] idx,
                           input logic [DW-1:0] data);
    start <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= dmm_pkg::REG_B_COLS) dims[idx] = data;
  endtask

  task automatic set_dims(input logic [DW-1:0] r, input logic [DW-1:0] n,
                          input logic [DW-1:0] c);
    write_reg(dmm_pkg::REG_A_ROWS, r);
    write_reg(dmm_pkg::REG_INNER_DIM, n);
    write_reg(dmm_pkg::REG_B_COLS, c);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random products, some loads cut short by a write mid-way
  task automatic run_phase(input int idle_pct, input int target);
    int sent;
    int total;
    int part;
    sent = 0;
    while (sent < target) begin
      settle();
      set_dims(pick_dim(), pick_dim(), pick_dim());
      total = load_length();
      if ($urandom_range(0, 99) < 20 && total > 1) begin
        part = $urandom_range(1, total - 1);
        send_random(part, idle_pct);
        sent += part;
        settle();
        if ($urandom_range(0, 1) == 1) begin
          // unused index: loading carries on where it was
          write_reg(REG_UNUSED, DW'($urandom));
          cfg_write <= 1'b0;
          total = total - part;
        end else begin
          write_reg(CW'($urandom_range(0, 2)), pick_dim());
          cfg_write <= 1'b0;
          total = load_length();
        end
      end
      send_random(total, idle_pct);
      sent += total;
      if ($urandom_range(0, 3) == 0) wait_for_results();
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    element_value <= '0;
    cfg_write <= 1'b0;
    cfg_index <= dmm_pkg::REG_A_ROWS;
    cfg_data <= '0;
    dims = '{dmm_pkg::DIM_RESET, dmm_pkg::DIM_RESET, dmm_pkg::DIM_RESET};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // range ends on a 2 x 1 by 1 x 2 product, zero inner dimension
    set_dims(4'd2, 4'd0, 4'd2);
    send_element(32'sh8000_0000);
    send_element(32'sh7FFF_FFFF);
    send_element(32'sh8000_0000);
    send_element(32'shFFFF_FFFF);
    settle();

    // zero rows and oversize inner dimension on corner values
    set_dims(4'd0, 4'd15, 4'd1);
    for (int i = 0; i < 16; i++) send_element(CORNER_VALUES[i]);
    settle();

    // unused index mid-load is ignored
    set_dims(4'd1, 4'd1, 4'd1);
    send_element(32'sh0003_0000);
    settle();
    write_reg(REG_UNUSED, 4'hF);
    cfg_write <= 1'b0;
    send_element(32'shFFFE_0000);
    settle();

    // a real write mid-load restarts with a
    send_element(32'sh7FFF_FFFF);
    settle();
    write_reg(dmm_pkg::REG_B_COLS, 4'd1);
    cfg_write <= 1'b0;
    send_element(32'sh0001_8000);
    send_element(32'shFFFF_8000);

    run_phase(19, 35);
    run_phase(85, 35);

    // full size result once, then back-to-back transactions
    settle();
    set_dims(4'd15, 4'd1, 4'd8);
    send_random(16, 0);
    run_phase(0, 30);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d elements over %0d dimension settings, %0d results checked",
             elements_sent, settings_used, results_seen);
    $display("sender gaps heavy, light and none; loads cut short and resumed");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
